@@ rtl/core/ddeb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddeb_pkg
// Shared types, constants and tables for the decimal digit emitter.
// ----------------------------------------------------------------------------
package ddeb_pkg;

  localparam int MAX_DIGITS = 7;
  localparam int VAL_W      = 24;
  localparam int CNT_W      = 3;
  localparam int POS_W      = 12;
  localparam int GLYPH_W    = 8;
  localparam int DIGIT_W    = 4;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CNTQ_W     = $clog2(QDEPTH + 1);

  localparam logic [GLYPH_W-1:0] GLYPH_BASE_RESET = 8'd36;
  localparam logic [GLYPH_W-1:0] X_STEP_RESET     = 8'd8;

  // register indexes
  localparam logic REG_GLYPH_BASE = 1'b0;
  localparam logic REG_X_STEP     = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } ddeb_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ddeb_qstat_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_base;
    logic [GLYPH_W-1:0] x_step;
  } ddeb_cfg_t;

  function automatic logic [VAL_W-1:0] pow10_f(input logic [CNT_W-1:0] n);
    logic [VAL_W-1:0] p;
    unique case (n)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
    endcase
    return p;
  endfunction

  // d times ten to the p
  function automatic logic [VAL_W-1:0] digit_mult_f(input logic [CNT_W-1:0] p,
                                                     input logic [DIGIT_W-1:0] d);
    logic [VAL_W+DIGIT_W-1:0] prod;
    prod = pow10_f(p) * d;
    return prod[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ddeb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddeb_front
// Accepts requests, clamps the count, drops empty runs and saturates values
// that do not fit before handing the job to the queue.
// ----------------------------------------------------------------------------
module ddeb_front import ddeb_pkg::*; (
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic [CNT_W-1:0] in_digit_count,
  input  wire logic [POS_W-1:0] in_pos_x,
  input  wire logic [POS_W-1:0] in_pos_y,
  input  wire ddeb_qstat_t      q_stat,
  output logic                  q_push,
  output ddeb_job_t             q_job
);

  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] limit;

  always_comb begin
    cnt = in_digit_count;
    if (32'(in_digit_count) > MAX_DIGITS) begin
      cnt = CNT_W'(MAX_DIGITS);
    end
    limit = pow10_f(cnt);
    q_job.cnt   = cnt;
    q_job.pos_x = in_pos_x;
    q_job.pos_y = in_pos_y;
    if (in_value >= limit) begin
      q_job.value = limit - VAL_W'(1);
      q_job.ovf   = 1'b1;
    end else begin
      q_job.value = in_value;
      q_job.ovf   = 1'b0;
    end
  end

  assign in_stall = q_stat.full;
  // zero count produces nothing, so the request is taken and dropped
  assign q_push   = in_valid && !q_stat.full && (cnt != '0);

endmodule
`default_nettype wire

@@ rtl/core/ddeb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddeb_queue
// Short job queue between the front and the digit sequencer.
// ----------------------------------------------------------------------------
module ddeb_queue import ddeb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire ddeb_job_t push_job,
  input  wire logic      pop,
  output ddeb_job_t      head_job,
  output ddeb_qstat_t    stat
);

  ddeb_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTQ_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == CNTQ_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTQ_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ddeb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddeb_back
// Digit sequencer: one decimal position per cycle while not stalled, most
// significant first, with leading blanking and a registered output stage.
// ----------------------------------------------------------------------------
module ddeb_back import ddeb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ddeb_cfg_t          cfg,
  input  wire ddeb_qstat_t        q_stat,
  input  wire ddeb_job_t          q_job,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [GLYPH_W-1:0]      out_glyph,
  output logic [POS_W-1:0]        out_glyph_x,
  output logic [POS_W-1:0]        out_glyph_y,
  output logic [DIGIT_W-1:0]      out_digit,
  output logic                    out_blank,
  output logic                    out_overflow,
  output logic                    out_last
);

  logic               busy_r, busy_nxt;
  logic [VAL_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   x_r, x_nxt;
  logic [POS_W-1:0]   y_r, y_nxt;
  logic               ovf_r, ovf_nxt;
  logic               lead_r, lead_nxt;

  logic               ov_r;
  logic [GLYPH_W-1:0] glyph_r;
  logic [POS_W-1:0]   gx_r, gy_r;
  logic [DIGIT_W-1:0] digit_r;
  logic               blank_r, ovfo_r, last_r;

  logic [VAL_W:0]     diff [1:9];
  logic [DIGIT_W-1:0] d;
  logic [VAL_W-1:0]   rem_sel;
  logic               is_last, is_blank, out_free, advance, load;

  // trial subtraction of every multiple of the current power in parallel
  always_comb begin
    d       = '0;
    rem_sel = rem_r;
    for (int i = 1; i <= 9; i++) begin
      diff[i] = {1'b0, rem_r} - {1'b0, digit_mult_f(pos_r, DIGIT_W'(i))};
    end
    for (int i = 1; i <= 9; i++) begin
      if (!diff[i][VAL_W]) begin
        d       = DIGIT_W'(i);
        rem_sel = diff[i][VAL_W-1:0];
      end
    end
  end

  assign is_last  = (pos_r == '0);
  assign is_blank = lead_r && (d == '0) && !is_last;
  assign out_free = !ov_r || !out_stall;
  assign advance  = busy_r && out_free;
  assign load     = !q_stat.empty && (!busy_r || (advance && is_last));
  assign q_pop    = load;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    pos_nxt  = pos_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    ovf_nxt  = ovf_r;
    lead_nxt = lead_r;
    if (advance) begin
      rem_nxt  = rem_sel;
      pos_nxt  = pos_r - CNT_W'(1);
      x_nxt    = x_r + POS_W'(cfg.x_step);
      lead_nxt = is_blank;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      rem_nxt  = q_job.value;
      pos_nxt  = q_job.cnt - CNT_W'(1);
      x_nxt    = q_job.pos_x;
      y_nxt    = q_job.pos_y;
      ovf_nxt  = q_job.ovf;
      lead_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (advance) begin
        ov_r <= 1'b1;
      end else if (out_free) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    pos_r  <= pos_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    ovf_r  <= ovf_nxt;
    lead_r <= lead_nxt;
    if (advance) begin
      glyph_r <= is_blank ? cfg.glyph_base : cfg.glyph_base + GLYPH_W'(d);
      gx_r    <= x_r;
      gy_r    <= y_r;
      digit_r <= d;
      blank_r <= is_blank;
      ovfo_r  <= ovf_r;
      last_r  <= is_last;
    end
  end

  assign out_valid    = ov_r;
  assign out_glyph    = glyph_r;
  assign out_glyph_x  = gx_r;
  assign out_glyph_y  = gy_r;
  assign out_digit    = digit_r;
  assign out_blank    = blank_r;
  assign out_overflow = ovfo_r;
  assign out_last     = last_r;

endmodule
`default_nettype wire

@@ rtl/core/decimal_digit_emitter_blanking.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_digit_emitter_blanking
// Path: front, job queue, digit sequencer, then the registered output stage.
// Output: one glyph per cycle while out_stall does not hold it, set by
//   the one-position-per-cycle digit sequencer; the next job loads during
//   the last glyph of the current one.
// Reset: synchronous active-low rst_n empties the queue and output stage and
//   sets glyph_base to 36 and x_step to 8.
// ----------------------------------------------------------------------------
module decimal_digit_emitter_blanking import ddeb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VAL_W-1:0]   in_value,
  input  wire logic [CNT_W-1:0]   in_digit_count,
  input  wire logic [POS_W-1:0]   in_pos_x,
  input  wire logic [POS_W-1:0]   in_pos_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [GLYPH_W-1:0]      out_glyph,
  output logic [POS_W-1:0]        out_glyph_x,
  output logic [POS_W-1:0]        out_glyph_y,
  output logic [DIGIT_W-1:0]      out_digit,
  output logic                    out_blank,
  output logic                    out_overflow,
  output logic                    out_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  ddeb_cfg_t   cfg_r;
  ddeb_qstat_t q_stat;
  ddeb_job_t   push_job, head_job;
  logic        q_push, q_pop, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_base <= GLYPH_BASE_RESET;
      cfg_r.x_step     <= X_STEP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_GLYPH_BASE: cfg_r.glyph_base <= pwdata[GLYPH_W-1:0];
        REG_X_STEP:     cfg_r.x_step     <= pwdata[GLYPH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GLYPH_BASE: prdata = {24'd0, cfg_r.glyph_base};
      REG_X_STEP:     prdata = {24'd0, cfg_r.x_step};
    endcase
  end

  ddeb_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  ddeb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  ddeb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_stat       (q_stat),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_glyph    (out_glyph),
    .out_glyph_x  (out_glyph_x),
    .out_glyph_y  (out_glyph_y),
    .out_digit    (out_digit),
    .out_blank    (out_blank),
    .out_overflow (out_overflow),
    .out_last     (out_last)
  );

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_ovf_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_blank)
    else $error("saturated run has a blanked position");

  a_last_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_blank)
    else $error("last position blanked");

  a_blank_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_blank |-> (out_digit == '0) && (out_glyph == cfg_r.glyph_base))
    else $error("blank position carries a digit");

endmodule
`default_nettype wire
